// ===== src/csdc_pkg.sv =====
// Shared types, constants and calendar helper functions for the calendar
// serial day converter. No dependencies; the stage modules and the top import it.
`default_nettype none

package csdc_pkg;

    // operation codes
    localparam logic OP_D2S = 1'b0;
    localparam logic OP_S2D = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_AW       = 1;
    localparam logic        REG_MIN_YEAR = 1'b0;
    localparam logic        REG_MAX_YEAR = 1'b1;

    localparam logic [13:0] MIN_YEAR_RST = 14'd1700;
    localparam logic [13:0] MAX_YEAR_RST = 14'd2900;
    localparam logic [10:0] MOD_MAX      = 11'd1439;

    // reciprocal constants: floor(v/d) = (v*K) >> SH over the operand range used
    localparam int unsigned K100  = 20972;     // 15-bit operands, shift 21
    localparam int unsigned K1461 = 23517960;  // 22-bit operand, 4/1461 with shift 33
    localparam int unsigned K60   = 2185;      // 11-bit operands, shift 17

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_DATE   = 2'd1,
        ST_BAD_SERIAL = 2'd2
    } t_status;

    typedef struct packed {
        logic        operation;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [21:0] serial_day;
        logic [10:0] minute_of_day;
    } t_item;

    // per-item context carried down the pipe
    typedef struct packed {
        logic        op;
        logic [21:0] serial;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [10:0] mod;     // minute of day: saturated input or hour*60+minute
        logic [4:0]  hour;    // hour split out of the minute of day
        logic        pre_ok;  // field checks that need no leap information
    } t_ctx;

    // year base results for a year and the year after it
    typedef struct packed {
        logic [13:0] ys;
        logic [23:0] base_a;
        logic [23:0] base_b;
        logic        leap_a;
        logic        leap_b;
    } t_yb;

    typedef struct packed {
        t_status     status;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [8:0]  doy;
        logic [21:0] serial;
        logic [10:0] mod;
    } t_res;

    function automatic logic [7:0] div100(input logic [14:0] v);
        logic [29:0] p;
        p = 30'(v) * 30'(K100);
        return p[28:21];
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
        logic [4:0] r;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:                                       r = lp ? 5'd29 : 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

    // days in the year before the first of month m
    function automatic logic [8:0] cum_before(input logic [3:0] m, input logic lp);
        logic [8:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        if (lp && m > 4'd2 && m < 4'd13) begin
            r = r + 9'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/csdc_in_if.sv =====
// Input channel of the calendar serial day converter: valid/ready plus item.
// No dependencies.
`default_nettype none

interface csdc_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [21:0] serial_day;
    logic [10:0] minute_of_day;

    modport source (
        output valid, operation, year, month, day, hour, minute, serial_day,
               minute_of_day,
        input  ready
    );
    modport sink (
        input  valid, operation, year, month, day, hour, minute, serial_day,
               minute_of_day,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/csdc_out_if.sv =====
// Result channel of the calendar serial day converter: valid/ready plus result.
// No dependencies.
`default_nettype none

interface csdc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [8:0]  day_of_year;
    logic [21:0] out_serial_day;
    logic [10:0] out_minute_of_day;

    modport source (
        output valid, status, out_year, out_month, out_day, out_hour, out_minute,
               day_of_year, out_serial_day, out_minute_of_day,
        input  ready
    );
    modport sink (
        input  valid, status, out_year, out_month, out_day, out_hour, out_minute,
               day_of_year, out_serial_day, out_minute_of_day,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/csdc_front.sv =====
// Stage 1: field checks, minute-of-day handling and year estimate from the
// serial day. Depends on csdc_pkg.
`default_nettype none

module csdc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  csdc_pkg::t_item    i_item,
    input  logic [13:0]        i_min_year,
    input  logic [13:0]        i_max_year,
    output logic               o_vld,
    output csdc_pkg::t_ctx     o_ctx,
    output logic [13:0]        o_ys
);
    import csdc_pkg::*;

    logic [21:0] x;
    logic [46:0] est_prod;
    logic [10:0] mod_sat;
    logic [22:0] hour_prod;
    logic [10:0] mod_d2s;
    t_ctx        n_ctx;
    logic [13:0] n_ys;

    logic        r_vld;
    t_ctx        r_ctx;
    logic [13:0] r_ys;

    always_comb begin
        // year estimate floor(4*(s-1)/1461)
        x         = i_item.serial_day - 22'd1;
        est_prod  = 47'(x) * 47'(K1461);
        mod_sat   = (i_item.minute_of_day > MOD_MAX) ? MOD_MAX : i_item.minute_of_day;
        hour_prod = 23'(mod_sat) * 23'(K60);
        mod_d2s   = 11'({i_item.hour, 6'b0}) - 11'({i_item.hour, 2'b0})
                  + 11'(i_item.minute);

        n_ctx.op     = i_item.operation;
        n_ctx.serial = i_item.serial_day;
        n_ctx.month  = i_item.month;
        n_ctx.day    = i_item.day;
        n_ctx.mod    = (i_item.operation == OP_S2D) ? mod_sat : mod_d2s;
        n_ctx.hour   = hour_prod[21:17];
        n_ctx.pre_ok = (i_item.minute <= 6'd59) && (i_item.hour <= 5'd23)
                    && (i_item.month >= 4'd1) && (i_item.month <= 4'd12)
                    && (i_item.day >= 5'd1)
                    && (i_item.year >= i_min_year) && (i_item.year <= i_max_year);
        n_ys = (i_item.operation == OP_S2D) ? est_prod[46:33] : i_item.year;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx <= n_ctx;
            r_ys  <= n_ys;
        end
    end

    assign o_vld = r_vld;
    assign o_ctx = r_ctx;
    assign o_ys  = r_ys;

endmodule

`default_nettype wire

// ===== src/csdc_ybase.sv =====
// Stages 2 to 4: serial day of 1 January and leap flag for a year and the
// year after it, built from reciprocal divides by 100. Depends on csdc_pkg.
`default_nettype none

module csdc_ybase (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  csdc_pkg::t_ctx     i_ctx,
    input  logic [13:0]        i_ys,
    output logic               o_vld,
    output csdc_pkg::t_ctx     o_ctx,
    output csdc_pkg::t_yb      o_yb
);
    import csdc_pkg::*;

    // base(y) = 1 + 365y + ceil(y/4) - ceil(y/100) + ceil(y/400)
    logic [14:0] ys15;
    logic [7:0]  n2_a, n2_b, n2_c;
    logic [12:0] n2_c4a, n2_c4b;

    logic        r2_vld;
    t_ctx        r2_ctx;
    logic [13:0] r2_ys;
    logic [7:0]  r2_a, r2_b, r2_c;
    logic [12:0] r2_c4a, r2_c4b;

    logic [14:0] ys1;
    logic [23:0] n3_pa, n3_pb;
    logic [7:0]  n3_qa, n3_qb;
    logic        n3_la, n3_lb;

    logic        r3_vld;
    t_ctx        r3_ctx;
    logic [13:0] r3_ys;
    logic [23:0] r3_pa, r3_pb;
    logic [7:0]  r3_qa, r3_qb;
    logic        r3_la, r3_lb;

    t_yb         n4_yb;
    logic        r4_vld;
    t_ctx        r4_ctx;
    t_yb         r4_yb;

    always_comb begin
        ys15   = {1'b0, i_ys};
        n2_a   = div100(ys15 + 15'd99);  // ceil(y/100)
        n2_b   = div100(ys15);           // floor(y/100)
        n2_c   = div100(ys15 + 15'd1);   // floor((y+1)/100)
        n2_c4a = 13'((ys15 + 15'd3) >> 2);
        n2_c4b = 13'((ys15 + 15'd4) >> 2);
    end

    always_comb begin
        ys1   = {1'b0, r2_ys} + 15'd1;
        n3_qa = div100(15'(r2_c4a) + 15'd99);  // ceil(y/400)
        n3_qb = div100(15'(r2_c4b) + 15'd99);
        n3_pa = 24'd1 + 24'(r2_ys) * 24'd365 + 24'(r2_c4a) - 24'(r2_a);
        // ceil((y+1)/100) is floor(y/100) + 1
        n3_pb = 24'(r2_ys) * 24'd365 + 24'd365 + 24'(r2_c4b) - 24'(r2_b);
        n3_la = (r2_ys[1:0] == 2'b00)
             && ((15'(r2_b) * 15'd100 != {1'b0, r2_ys}) || (r2_b[1:0] == 2'b00));
        n3_lb = (ys1[1:0] == 2'b00)
             && ((15'(r2_c) * 15'd100 != ys1) || (r2_c[1:0] == 2'b00));
    end

    always_comb begin
        n4_yb.ys     = r3_ys;
        n4_yb.base_a = r3_pa + 24'(r3_qa);
        n4_yb.base_b = r3_pb + 24'(r3_qb);
        n4_yb.leap_a = r3_la;
        n4_yb.leap_b = r3_lb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= i_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ctx <= i_ctx;
            r2_ys  <= i_ys;
            r2_a   <= n2_a;
            r2_b   <= n2_b;
            r2_c   <= n2_c;
            r2_c4a <= n2_c4a;
            r2_c4b <= n2_c4b;
            r3_ctx <= r2_ctx;
            r3_ys  <= r2_ys;
            r3_pa  <= n3_pa;
            r3_pb  <= n3_pb;
            r3_qa  <= n3_qa;
            r3_qb  <= n3_qb;
            r3_la  <= n3_la;
            r3_lb  <= n3_lb;
            r4_ctx <= r3_ctx;
            r4_yb  <= n4_yb;
        end
    end

    assign o_vld = r4_vld;
    assign o_ctx = r4_ctx;
    assign o_yb  = r4_yb;

endmodule

`default_nettype wire

// ===== src/csdc_back.sv =====
// Stages 5 to 7: year choice and day of year, serial sum and month search,
// day of month and result assembly into the output register.
// Depends on csdc_pkg.
`default_nettype none

module csdc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  csdc_pkg::t_ctx     i_ctx,
    input  csdc_pkg::t_yb      i_yb,
    output logic               o_vld,
    output csdc_pkg::t_res     o_res
);
    import csdc_pkg::*;

    // stage 5
    logic        sel_b;
    logic [23:0] s_diff;
    logic [8:0]  doy_d2s;
    logic [8:0]  n5_dr;
    logic        n5_lp;
    logic [13:0] n5_year;
    logic        n5_ok;

    logic        r5_vld;
    t_ctx        r5_ctx;
    logic [23:0] r5_base;
    logic [8:0]  r5_dr;     // day of year (zero based) in both directions
    logic        r5_lp;
    logic [13:0] r5_year;
    logic        r5_ok;

    // stage 6
    logic [23:0] sum6;
    logic [8:0]  r1_6;
    logic [3:0]  n6_mon;

    logic        r6_vld;
    t_ctx        r6_ctx;
    logic [21:0] r6_serial;
    logic        r6_ok;
    logic [8:0]  r6_dr;
    logic [8:0]  r6_r1;
    logic [3:0]  r6_mon;
    logic        r6_lp;
    logic [13:0] r6_year;

    // stage 7
    logic [8:0]  day_diff;
    logic [10:0] hour_min;
    logic [10:0] min_diff;
    t_res        n7_res;

    logic        r7_vld;
    t_res        r7_res;

    always_comb begin
        sel_b   = i_yb.base_b <= 24'(i_ctx.serial);
        s_diff  = 24'(i_ctx.serial) - (sel_b ? i_yb.base_b : i_yb.base_a);
        doy_d2s = cum_before(i_ctx.month, i_yb.leap_a) + 9'(i_ctx.day) - 9'd1;
        if (i_ctx.op == OP_S2D) begin
            n5_dr   = s_diff[8:0];
            n5_lp   = sel_b ? i_yb.leap_b : i_yb.leap_a;
            n5_year = sel_b ? (i_yb.ys + 14'd1) : i_yb.ys;
        end else begin
            n5_dr   = doy_d2s;
            n5_lp   = i_yb.leap_a;
            n5_year = i_yb.ys;
        end
        n5_ok = i_ctx.pre_ok && (i_ctx.day <= month_len(i_ctx.month, i_yb.leap_a));
    end

    always_comb begin
        sum6   = r5_base + 24'(r5_dr);
        r1_6   = r5_dr + 9'd1;
        // month = 1 + number of month ends passed by the one-based day
        n6_mon = 4'd1;
        for (int j = 2; j <= 12; j++) begin
            if (r1_6 > cum_before(4'(j), r5_lp)) begin
                n6_mon = n6_mon + 4'd1;
            end
        end
    end

    always_comb begin
        day_diff = r6_r1 - cum_before(r6_mon, r6_lp);
        hour_min = 11'({r6_ctx.hour, 6'b0}) - 11'({r6_ctx.hour, 2'b0});
        min_diff = r6_ctx.mod - hour_min;

        n7_res = '0;
        n7_res.status = ST_OK;
        if (r6_ctx.op == OP_D2S) begin
            if (!r6_ok) begin
                n7_res.status = ST_BAD_DATE;
            end else begin
                n7_res.doy    = r6_dr;
                n7_res.serial = r6_serial;
                n7_res.mod    = r6_ctx.mod;
            end
        end else begin
            if (r6_ctx.serial == 22'd0) begin
                n7_res.status = ST_BAD_SERIAL;
            end else begin
                n7_res.year   = r6_year;
                n7_res.month  = r6_mon;
                n7_res.day    = day_diff[4:0];
                n7_res.hour   = r6_ctx.hour;
                n7_res.minute = min_diff[5:0];
                n7_res.doy    = r6_dr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (i_en) begin
            r5_vld <= i_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_ctx    <= i_ctx;
            r5_base   <= i_yb.base_a;
            r5_dr     <= n5_dr;
            r5_lp     <= n5_lp;
            r5_year   <= n5_year;
            r5_ok     <= n5_ok;
            r6_ctx    <= r5_ctx;
            r6_serial <= sum6[21:0];
            r6_ok     <= r5_ok && (sum6[23:22] == 2'b00);
            r6_dr     <= r5_dr;
            r6_r1     <= r1_6;
            r6_mon    <= n6_mon;
            r6_lp     <= r5_lp;
            r6_year   <= r5_year;
            r7_res    <= n7_res;
        end
    end

    assign o_vld = r7_vld;
    assign o_res = r7_res;

endmodule

`default_nettype wire

// ===== src/calendar_serial_day_converter_top.sv =====
// Top level of the calendar serial day converter: config registers, pipeline
// control and channel wiring. Depends on csdc_pkg, csdc_in_if, csdc_out_if,
// csdc_front, csdc_ybase and csdc_back.
`default_nettype none

// Converts a proleptic Gregorian date and time to a serial day (day 1 is
// 1 January of year 0) and minute of day, or a serial day and minute of day
// back to a date, chosen per item by operation. One item is taken every
// clock unless the pipe holds; each result passes the seven register stages
// (year estimate by reciprocal multiply, three stages of year-base arithmetic
// built on divide-by-100 multipliers, year choice, month search, result
// register). The whole pipe holds while a result waits and the output is not
// ready, and input ready is low in that same cycle. min_year and max_year are
// to be written through the config port only while the block is idle, which
// it does not enforce; they bound the years accepted by date to serial.
module calendar_serial_day_converter_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    csdc_in_if.sink                        i_in,
    csdc_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [csdc_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [13:0]                    i_cfg_wdata
);
    import csdc_pkg::*;

    logic [13:0] r_min_year;
    logic [13:0] r_max_year;

    logic        en;
    t_item       item;
    logic        f_vld;
    t_ctx        f_ctx;
    logic [13:0] f_ys;
    logic        y_vld;
    t_ctx        y_ctx;
    t_yb         y_yb;
    logic        b_vld;
    t_res        b_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= MIN_YEAR_RST;
            r_max_year <= MAX_YEAR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_MIN_YEAR: r_min_year <= i_cfg_wdata;
                REG_MAX_YEAR: r_max_year <= i_cfg_wdata;
            endcase
        end
    end

    // every stage advances together unless a result is stuck at the output
    assign en         = !b_vld || o_out.ready;
    assign i_in.ready = en;

    always_comb begin
        item.operation     = i_in.operation;
        item.year          = i_in.year;
        item.month         = i_in.month;
        item.day           = i_in.day;
        item.hour          = i_in.hour;
        item.minute        = i_in.minute;
        item.serial_day    = i_in.serial_day;
        item.minute_of_day = i_in.minute_of_day;
    end

    csdc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (i_in.valid),
        .i_item     (item),
        .i_min_year (r_min_year),
        .i_max_year (r_max_year),
        .o_vld      (f_vld),
        .o_ctx      (f_ctx),
        .o_ys       (f_ys)
    );

    csdc_ybase u_ybase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_ctx   (f_ctx),
        .i_ys    (f_ys),
        .o_vld   (y_vld),
        .o_ctx   (y_ctx),
        .o_yb    (y_yb)
    );

    csdc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (y_vld),
        .i_ctx   (y_ctx),
        .i_yb    (y_yb),
        .o_vld   (b_vld),
        .o_res   (b_res)
    );

    assign o_out.valid             = b_vld;
    assign o_out.status            = b_res.status;
    assign o_out.out_year          = b_res.year;
    assign o_out.out_month         = b_res.month;
    assign o_out.out_day           = b_res.day;
    assign o_out.out_hour          = b_res.hour;
    assign o_out.out_minute        = b_res.minute;
    assign o_out.day_of_year       = b_res.doy;
    assign o_out.out_serial_day    = b_res.serial;
    assign o_out.out_minute_of_day = b_res.mod;

endmodule

`default_nettype wire
